// ===== hdl/krl_pkg.sv =====
// krl_pkg: types, codes and sizes shared by the keyed record list.
// Depends on nothing; every other file imports it.
`default_nettype none
package krl_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_DISPLAY = 3'd1;
    localparam logic [2:0] CMD_SEARCH  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_ALTER   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] key;
        logic signed [31:0] new_key;
        logic [63:0]        name_low;
        logic [15:0]        name_high;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] key_res;
        logic [63:0]        name_low_res;
        logic [15:0]        name_high_res;
        logic               last;
    } out_word_t;

endpackage
`default_nettype wire

// ===== hdl/krl_front.sv =====
// krl_front: accepts command words, drops unknown codes, queues the rest.
// Depends on krl_pkg.
`default_nettype none
module krl_front (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    output logic               full,
    input  krl_pkg::in_word_t  in_word,
    output logic               q_valid,
    input  wire                q_take,
    output krl_pkg::in_word_t  q_word
);
    import krl_pkg::*;

    in_word_t  mem_reg [CMDQ_DEPTH];
    logic      wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      acc, keep;

    assign full    = (cnt_reg == 2'(CMDQ_DEPTH));
    assign acc     = push && !full;
    assign keep    = acc && (in_word.command <= CMD_ALTER);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = keep ? !wr_reg : wr_reg;
        rd_next  = q_take ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(keep) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            mem_reg[wr_reg] <= in_word;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/krl_back.sv =====
// krl_back: record table and command sequencer; scans, shifts and reports.
// Depends on krl_pkg.
`default_nettype none
module krl_back #(
    parameter int DEPTH = krl_pkg::DEPTH_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                q_valid,
    output logic               q_take,
    input  krl_pkg::in_word_t  q_word,
    output logic               empty,
    input  wire                pop,
    output krl_pkg::out_word_t out_word
);
    import krl_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_READ  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    logic [31:0] key_mem [DEPTH];
    logic [63:0] nlo_mem [DEPTH];
    logic [15:0] nhi_mem [DEPTH];

    state_t     state_reg, state_next;
    in_word_t   cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    out_word_t  out_reg, out_next;
    logic       rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0] rd_key;
    logic [63:0] rd_nlo;
    logic [15:0] rd_nhi;
    logic       wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0] wr_key;
    logic [63:0] wr_nlo;
    logic [15:0] wr_nhi;
    logic       slot_free;

    assign empty     = !ovalid_reg;
    assign out_word  = out_reg;
    assign slot_free = !ovalid_reg || pop;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            nlo_mem[wr_addr] <= wr_nlo;
            nhi_mem[wr_addr] <= wr_nhi;
        end
        if (rd_en)
        begin
            rd_key <= key_mem[rd_addr];
            rd_nlo <= nlo_mem[rd_addr];
            rd_nhi <= nhi_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !pop;
        out_next    = out_reg;
        q_take      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[IW-1:0];
        wr_key      = cmd_reg.key;
        wr_nlo      = cmd_reg.name_low;
        wr_nhi      = cmd_reg.name_high;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_take   = 1'b1;
                    cmd_next = q_word;
                    idx_next = '0;
                    ovalid_next = 1'b1;
                    out_next = '{ST_OK, 32'sd0, 64'd0, 16'd0, 1'b1};
                    if (q_word.command == CMD_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            out_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = count_reg[IW-1:0];
                            wr_key  = q_word.key;
                            wr_nlo  = q_word.name_low;
                            wr_nhi  = q_word.name_high;
                            count_next = count_reg + 1'b1;
                            out_next = '{ST_OK, q_word.key, q_word.name_low,
                                         q_word.name_high, 1'b1};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ovalid_next = ovalid_reg && !pop;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = (cmd_reg.command == CMD_DISPLAY) ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_key == cmd_reg.key)
                begin
                    state_next = S_EMIT;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    if (slot_free)
                    begin
                        ovalid_next = 1'b1;
                        out_next = '{ST_NOT_FOUND, 32'sd0, 64'd0, 16'd0, 1'b1};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = idx_next[IW-1:0];
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    out_next = '{ST_OK, rd_key, rd_nlo, rd_nhi, 1'b1};
                    case (cmd_reg.command)
                        CMD_DISPLAY:
                        begin
                            if (idx_reg + 1'b1 == count_reg)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                out_next.last = 1'b0;
                                idx_next   = idx_reg + 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = idx_next[IW-1:0];
                                state_next = S_READ;
                            end
                        end
                        CMD_ALTER:
                        begin
                            out_next.key_res = cmd_reg.new_key;
                            wr_en   = 1'b1;
                            wr_key  = cmd_reg.new_key;
                            wr_nlo  = rd_nlo;
                            wr_nhi  = rd_nhi;
                            state_next = S_IDLE;
                        end
                        CMD_REMOVE:
                        begin
                            if (idx_reg + 1'b1 == count_reg)
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = IW'(idx_reg + 1'b1);
                                state_next = S_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_key = rd_key;
                wr_nlo = rd_nlo;
                wr_nhi = rd_nhi;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 2'd2 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(idx_reg + 2'd2);
                    state_next = S_WAIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        out_reg <= out_next;
    end
endmodule
`default_nettype wire

// ===== hdl/keyed_record_list.sv =====
// keyed_record_list: top level; joins the command queue to the table sequencer.
// Depends on krl_pkg, krl_front and krl_back.
//
// A table of up to DEPTH records (signed key, 10-byte name) in insertion order,
// driven by insert, display, search, remove and alter words. Words enter a
// two-entry queue; one command runs at a time. Insert and empty/full replies
// are registered straight from idle; search, alter and remove scan records
// one by one (S_READ, S_SCAN) over a table memory with one read and one
// write port; remove then moves each later record up (S_WAIT, S_SHIFT);
// display gives a word per record. Codes 5 to 7 are dropped with no result.
`default_nettype none
module keyed_record_list #(
    parameter int DEPTH = krl_pkg::DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    output logic                full,
    input  krl_pkg::in_word_t   in_word,
    output logic                empty,
    input  wire                 pop,
    output krl_pkg::out_word_t  out_word
);
    import krl_pkg::*;

    logic     q_valid, q_take;
    in_word_t q_word;

    krl_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
    );

    krl_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_word(q_word), .empty(empty), .pop(pop), .out_word(out_word)
    );

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("queue read while empty");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_word)))
        else $error("waiting result changed");
    a_no_dropped_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.status == ST_FULL) |-> out_word.key_res == 32'sd0)
        else $error("full status carries a record");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: randomised regression for keyed_record_list with a table predictor.
// Depends on krl_pkg and the keyed_record_list RTL; reads no files.
`timescale 1ns / 100ps
`default_nettype none

class record_table_board;
    logic signed [31:0] keys[$];
    logic [63:0]        nlo[$];
    logic [15:0]        nhi[$];
    krl_pkg::out_word_t pending[$];
    int                 errors;

    function new();
        errors = 0;
    endfunction

    function int find_first(logic signed [31:0] k);
        int i;
        for (i = 0; i < keys.size(); i++)
            if (keys[i] == k)
                return i;
        return -1;
    endfunction

    function void note_word(krl_pkg::in_word_t w);
        krl_pkg::out_word_t r;
        int i;
        r = '0;
        r.last = 1'b1;
        if (w.command > krl_pkg::CMD_ALTER)
            return;
        if (w.command == krl_pkg::CMD_INSERT) begin
            if (keys.size() >= krl_pkg::DEPTH_DEF) begin
                r.status = krl_pkg::ST_FULL;
            end else begin
                keys.push_back(w.key);
                nlo.push_back(w.name_low);
                nhi.push_back(w.name_high);
                r.status = krl_pkg::ST_OK;
                r.key_res = w.key;
                r.name_low_res = w.name_low;
                r.name_high_res = w.name_high;
            end
            pending.push_back(r);
            return;
        end
        if (keys.size() == 0) begin
            r.status = krl_pkg::ST_EMPTY;
            pending.push_back(r);
            return;
        end
        if (w.command == krl_pkg::CMD_DISPLAY) begin
            for (i = 0; i < keys.size(); i++) begin
                r.status = krl_pkg::ST_OK;
                r.key_res = keys[i];
                r.name_low_res = nlo[i];
                r.name_high_res = nhi[i];
                r.last = (i == keys.size() - 1);
                pending.push_back(r);
            end
            return;
        end
        i = find_first(w.key);
        if (i < 0) begin
            r.status = krl_pkg::ST_NOT_FOUND;
            pending.push_back(r);
            return;
        end
        if (w.command == krl_pkg::CMD_ALTER)
            keys[i] = w.new_key;
        r.status = krl_pkg::ST_OK;
        r.key_res = keys[i];
        r.name_low_res = nlo[i];
        r.name_high_res = nhi[i];
        pending.push_back(r);
        if (w.command == krl_pkg::CMD_REMOVE) begin
            keys.delete(i);
            nlo.delete(i);
            nhi.delete(i);
        end
    endfunction

    function void check_word(krl_pkg::out_word_t got);
        krl_pkg::out_word_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.key_res !== want.key_res)
            $display("%0t: key exp %0d got %0d", $time, want.key_res, got.key_res);
        if (got.name_low_res !== want.name_low_res)
            $display("%0t: name_low exp %h got %h", $time,
                     want.name_low_res, got.name_low_res);
        if (got.name_high_res !== want.name_high_res)
            $display("%0t: name_high exp %h got %h", $time,
                     want.name_high_res, got.name_high_res);
        if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
        if (got !== want)
            errors++;
    endfunction
endclass

module testbench;
    import krl_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  in_word;
    logic      empty;
    logic      pop;
    out_word_t out_word;

    record_table_board board;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    logic signed [31:0] used_keys[$];

    keyed_record_list u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
        .empty(empty), .pop(pop), .out_word(out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                board.note_word(in_word);
            if (pop && !empty)
                board.check_word(out_word);
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("keyed_record_list regression: fail");
            $finish;
        end
    end

    function logic signed [31:0] pick_key();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return used_keys.size() ? used_keys[$urandom_range(used_keys.size() - 1)]
                                             : $urandom_range(3);
        endcase
    endfunction

    task send_word(input logic [2:0] cmd, input logic signed [31:0] k,
                   input logic signed [31:0] nk, input logic [63:0] lo,
                   input logic [15:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        in_word <= '{command: cmd, key: k, new_key: nk, name_low: lo, name_high: hi};
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (cmd == CMD_INSERT || cmd == CMD_ALTER)
            used_keys.push_back(cmd == CMD_ALTER ? nk : k);
        if (used_keys.size() > 24)
            void'(used_keys.pop_front());
    endtask

    task send_random();
        int c;
        c = $urandom_range(99);
        if (c < 35)
            send_word(CMD_INSERT, pick_key(), $urandom, {$urandom, $urandom},
                      16'($urandom));
        else if (c < 45)
            send_word(CMD_DISPLAY, $urandom, $urandom, {$urandom, $urandom},
                      16'($urandom));
        else if (c < 65)
            send_word(CMD_SEARCH, pick_key(), $urandom, {$urandom, $urandom},
                      16'($urandom));
        else if (c < 83)
            send_word(CMD_REMOVE, pick_key(), $urandom, {$urandom, $urandom},
                      16'($urandom));
        else if (c < 97)
            send_word(CMD_ALTER, pick_key(), pick_key(), {$urandom, $urandom},
                      16'($urandom));
        else
            send_word(3'($urandom_range(7, 5)), $urandom, $urandom,
                      {$urandom, $urandom}, 16'($urandom));
    endtask

    initial
    begin
        int i;
        int ph;
        board = new();
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_word = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_DISPLAY, 0, 0, 0, 0);
        send_word(CMD_SEARCH, 5, 0, 0, 0);
        send_word(CMD_REMOVE, 5, 0, 0, 0);
        send_word(CMD_ALTER, 5, 6, 0, 0);
        send_word(3'd7, 0, 0, 0, 0);
        send_word(CMD_INSERT, 32'sh7fffffff, 0, '1, '1);
        send_word(CMD_INSERT, 32'sh80000000, 0, '0, '0);
        send_word(CMD_INSERT, 32'sh7fffffff, 0, 64'h0123456789abcdef, 16'h5aa5);
        for (i = 0; i < 14; i++)
            send_word(CMD_INSERT, i, 0, {$urandom, $urandom}, 16'($urandom));
        send_word(CMD_DISPLAY, 0, 0, 0, 0);
        send_word(CMD_SEARCH, 32'sh7fffffff, 0, 0, 0);
        send_word(CMD_ALTER, 32'sh80000000, 32'sh7fffffff, 0, 0);
        send_word(CMD_SEARCH, 99, 0, 0, 0);
        send_word(CMD_REMOVE, 32'sh7fffffff, 0, 0, 0);
        send_word(CMD_REMOVE, 13, 0, 0, 0);
        send_word(CMD_DISPLAY, 0, 0, 0, 0);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (i = 0; i < 88; i++)
                send_random();
        end
        push <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("keyed_record_list regression: pass");
        else
            $display("keyed_record_list regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== keyed_record_list.f =====
hdl/krl_pkg.sv
hdl/krl_front.sv
hdl/krl_back.sv
hdl/keyed_record_list.sv
tb/testbench.sv
